@@ hdl/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue core and its cells.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd4;
  localparam logic [ACT_W-1:0] ACT_STATUS     = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  localparam logic signed [WORD_W-1:0] NO_WORD = '1;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    CO_HOLD,
    CO_SHIFT_R,   // push front: take the left neighbour's word
    CO_SHIFT_L,   // pop front: take the right neighbour's word
    CO_APPEND,    // push back: first free cell loads the value
    CO_TRIM,      // pop back: last occupied cell drops out
    CO_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [WORD_W-1:0]  value;
  } cell_ctl_t;

endpackage

@@ hdl/dq_cell.sv @@
// ----------------------------------------------------------------------------
// dq_cell
// One slot of the queue chain: a word and an occupied flag, moved to or
// taken from its neighbours as the broadcast command says.
// ----------------------------------------------------------------------------
module dq_cell
  import dq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_ctl_t                ctl,
  input  logic signed [WORD_W-1:0] left_word,
  input  logic                     left_v,
  input  logic signed [WORD_W-1:0] right_word,
  input  logic                     right_v,
  output logic signed [WORD_W-1:0] word,
  output logic                     valid,
  output logic signed [WORD_W-1:0] back_part
);

  logic signed [WORD_W-1:0] word_r, word_nxt;
  logic                     valid_r, valid_nxt;

  always_comb begin
    word_nxt  = word_r;
    valid_nxt = valid_r;
    case (ctl.op)
      CO_SHIFT_R: begin
        word_nxt  = left_word;
        valid_nxt = left_v;
      end
      CO_SHIFT_L: begin
        word_nxt  = right_word;
        valid_nxt = right_v;
      end
      CO_APPEND: begin
        if (!valid_r && left_v) begin
          word_nxt  = ctl.value;
          valid_nxt = 1'b1;
        end
      end
      CO_TRIM: begin
        if (valid_r && !right_v) valid_nxt = 1'b0;
      end
      CO_CLEAR: valid_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word  = word_r;
  assign valid = valid_r;
  // only the last occupied cell contributes to the back word
  assign back_part = (valid_r && !right_v) ? word_r : '0;

endmodule

@@ hdl/double_ended_queue_core.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded deque of signed words held in a chain of cells, front at cell 0.
//
//   channel | direction | fields
//   in      | sink      | action, push_value
//   out     | source    | status, popped_value, front_value, back_value,
//           |           | entry_count, is_empty
//
// The cell chain updates at the accept edge, and the next cycle selects the
// back word from the chain and loads the result register. A new beat is
// taken in the cycle the result leaves.
// Reset clears only the state, the occupied flags and the count; words need no clear.
// A stalled result holds and blocks further input until taken.
// ----------------------------------------------------------------------------
module double_ended_queue_core
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [WORD_W-1:0] in_push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [WORD_W-1:0] out_popped_value,
  output logic signed [WORD_W-1:0] out_front_value,
  output logic signed [WORD_W-1:0] out_back_value,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic                     out_is_empty
);

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_SHOW} state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [STAT_W-1:0]        status_r, status_nxt;
  logic signed [WORD_W-1:0] popped_r, popped_nxt;
  logic signed [WORD_W-1:0] front_r;
  logic signed [WORD_W-1:0] back_r;
  cell_ctl_t                ctl;
  logic                     in_fire, full, empty;

  logic signed [WORD_W-1:0] word_a [DEPTH];
  logic                     v_a    [DEPTH];
  logic signed [WORD_W-1:0] part_a [DEPTH];
  logic signed [WORD_W-1:0] back_sel;

  assign in_ready = (state_r == S_IDLE) || (state_r == S_SHOW && out_ready);
  assign in_fire  = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    ctl.op     = CO_HOLD;
    ctl.value  = in_push_value;
    count_nxt  = count_r;
    status_nxt = STAT_OK;
    popped_nxt = NO_WORD;
    case (in_action)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          ctl.op    = (in_action == ACT_PUSH_BACK) ? CO_APPEND : CO_SHIFT_R;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_POP_BACK, ACT_POP_FRONT: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          ctl.op     = (in_action == ACT_POP_BACK) ? CO_TRIM : CO_SHIFT_L;
          popped_nxt = (in_action == ACT_POP_BACK) ? back_r : word_a[0];
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      ACT_CLEAR: begin
        ctl.op    = CO_CLEAR;
        count_nxt = '0;
      end
      default: ;
    endcase
    if (!in_fire) ctl.op = CO_HOLD;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] lw, rw;
    logic                     lv, rv;
    if (i == 0) begin : g_first
      assign lw = in_push_value;
      assign lv = 1'b1;
    end else begin : g_mid_l
      assign lw = word_a[i-1];
      assign lv = v_a[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rw = '0;
      assign rv = 1'b0;
    end else begin : g_mid_r
      assign rw = word_a[i+1];
      assign rv = v_a[i+1];
    end
    dq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_word  (lw),
      .left_v     (lv),
      .right_word (rw),
      .right_v    (rv),
      .word       (word_a[i]),
      .valid      (v_a[i]),
      .back_part  (part_a[i])
    );
  end

  // one-hot select of the back word: at most one cell is non-zero
  always_comb begin
    back_sel = '0;
    for (int i = 0; i < DEPTH; i++) back_sel = back_sel | part_a[i];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_CALC;
      S_CALC: state_nxt = S_SHOW;
      S_SHOW: begin
        if (in_fire)        state_nxt = S_CALC;
        else if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        count_r  <= count_nxt;
        status_r <= status_nxt;
        popped_r <= popped_nxt;
      end
      if (state_r == S_CALC) begin
        front_r <= v_a[0] ? word_a[0] : NO_WORD;
        back_r  <= empty ? NO_WORD : back_sel;
      end
    end
  end

  assign out_valid        = (state_r == S_SHOW);
  assign out_status       = status_r;
  assign out_popped_value = popped_r;
  assign out_front_value  = front_r;
  assign out_back_value   = back_r;
  assign out_entry_count  = count_r;
  assign out_is_empty     = empty;

endmodule

@@ hdl/dq_checker.sv @@
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the deque core, bound to the core module.
// ----------------------------------------------------------------------------
module dq_checker
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [STAT_W-1:0]        out_status,
  input  logic signed [WORD_W-1:0] out_popped_value,
  input  logic signed [WORD_W-1:0] out_front_value,
  input  logic signed [WORD_W-1:0] out_back_value,
  input  logic [CNT_W-1:0]         out_entry_count,
  input  logic                     out_is_empty
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_popped_value) && $stable(out_entry_count))
    else $error("result beat changed while stalled");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(DEPTH)
      && out_is_empty == (out_entry_count == '0))
    else $error("count out of range or empty flag wrong");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_front_value == NO_WORD
      && out_back_value == NO_WORD)
    else $error("ends not reported as empty");

  a_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY || out_status == STAT_FULL)
      |-> out_popped_value == NO_WORD)
    else $error("popped word on failed operation");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result shown in cycle after accept");

endmodule

bind double_ended_queue_core dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for double_ended_queue_core. A short table of directed
// beats covers empty pops, full pushes, clears and the spare action codes. A
// long run of random beats follows, biased in turn towards filling and
// draining. Every result is checked against a queue-based model of the deque.
// ----------------------------------------------------------------------------
module tb;
  import dq_pkg::*;

  localparam int QDEPTH   = DEPTH_DEF;
  localparam int CNT_W    = $clog2(QDEPTH + 1);
  localparam int N_RANDOM = 1330;
  localparam int PHASE_LEN = 48;
  localparam int HOLD_AT   = 400;   // beats sent before the long output stall
  localparam int HOLD_LEN  = 300;

  // spare codes, treated by the core as a status read
  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] popped;
    logic signed [WORD_W-1:0] front;
    logic signed [WORD_W-1:0] back;
    logic [CNT_W-1:0]         count;
    logic                     empty;
  } deque_result_t;

  typedef struct {
    logic [ACT_W-1:0]         act;
    logic signed [WORD_W-1:0] val;
    int                       reps;
    bit                       fixed;   // expectation is an empty queue with given status
    logic [STAT_W-1:0]        fixed_status;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [ACT_W-1:0]         in_action;
  logic signed [WORD_W-1:0] in_push_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [STAT_W-1:0]        out_status;
  logic signed [WORD_W-1:0] out_popped_value;
  logic signed [WORD_W-1:0] out_front_value;
  logic signed [WORD_W-1:0] out_back_value;
  logic [CNT_W-1:0]         out_entry_count;
  logic                     out_is_empty;

  deque_result_t            results_due[$];
  logic signed [WORD_W-1:0] shadow_words[$];
  stim_row_t                dir_rows[$];
  int                       errors;
  int                       beats_sent;

  double_ended_queue_core #(.DEPTH(QDEPTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

  // Apply one operation to the shadow deque and return what the core should report.
  function automatic deque_result_t predict_deque(input logic [ACT_W-1:0] act,
                                                  input logic signed [WORD_W-1:0] val);
    deque_result_t r;
    r.status = STAT_OK;
    r.popped = NO_WORD;
    case (act)
      ACT_PUSH_BACK: begin
        if (shadow_words.size() >= QDEPTH) r.status = STAT_FULL;
        else shadow_words.insert(shadow_words.size(), val);
      end
      ACT_PUSH_FRONT: begin
        if (shadow_words.size() >= QDEPTH) r.status = STAT_FULL;
        else shadow_words.insert(0, val);
      end
      ACT_POP_BACK: begin
        if (shadow_words.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped = shadow_words[$];
          shadow_words.delete(shadow_words.size() - 1);
        end
      end
      ACT_POP_FRONT: begin
        if (shadow_words.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped = shadow_words[0];
          shadow_words.delete(0);
        end
      end
      ACT_CLEAR: shadow_words.delete();
      default: ;
    endcase
    r.front = (shadow_words.size() != 0) ? shadow_words[0] : NO_WORD;
    r.back  = (shadow_words.size() != 0) ? shadow_words[$] : NO_WORD;
    r.count = CNT_W'(shadow_words.size());
    r.empty = (shadow_words.size() == 0);
    return r;
  endfunction

  // mostly back-to-back, now and then a long gap
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic signed [WORD_W-1:0] rand_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return $urandom;
    case (roll % 4)
      0: return '0;
      1: return NO_WORD;
      2: return 32'sh7fff_ffff;
      default: return 32'sh8000_0000;
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] rand_action(input bit filling);
    int  roll;
    bit  push;
    roll = $urandom_range(99);
    if (roll < 3) return ACT_CLEAR;
    if (roll < 9) begin
      case ($urandom_range(2))
        0: return ACT_STATUS;
        1: return ACT_SPARE_6;
        default: return ACT_SPARE_7;
      endcase
    end
    push = ($urandom_range(99) < 70) ? filling : !filling;
    if (push) return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
  endfunction

  task automatic add_row(input logic [ACT_W-1:0] act, input logic signed [WORD_W-1:0] val,
                         input int reps, input bit fixed, input logic [STAT_W-1:0] st);
    stim_row_t row;
    row.act = act;
    row.val = val;
    row.reps = reps;
    row.fixed = fixed;
    row.fixed_status = st;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Offer one beat, hold it until taken, then log what should come back.
  task automatic send_beat(input logic [ACT_W-1:0] act, input logic signed [WORD_W-1:0] val,
                           input bit fixed, input logic [STAT_W-1:0] st);
    int            gap;
    deque_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_push_value <= val;
    do @(posedge clk); while (!in_ready);
    r = predict_deque(act, val);
    if (fixed) begin
      r.status = st;
      r.popped = NO_WORD;
      r.front  = NO_WORD;
      r.back   = NO_WORD;
      r.count  = '0;
      r.empty  = 1'b1;
    end
    results_due.insert(results_due.size(), r);
    beats_sent++;
  endtask

  initial begin
    stim_row_t        row;
    logic [ACT_W-1:0] act;
    bit               filling;

    errors        = 0;
    beats_sent    = 0;
    filling       = 1'b1;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_action     <= ACT_STATUS;
    in_push_value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    add_row(ACT_STATUS,     '0,              1,  1, STAT_OK);
    add_row(ACT_POP_BACK,   '0,              1,  1, STAT_EMPTY);
    add_row(ACT_POP_FRONT,  '0,              1,  1, STAT_EMPTY);
    add_row(ACT_PUSH_BACK,  32'sh7fff_ffff,  1,  0, STAT_OK);
    add_row(ACT_PUSH_FRONT, 32'sh8000_0000,  1,  0, STAT_OK);
    add_row(ACT_SPARE_6,    32'sh1234_5678,  1,  0, STAT_OK);
    add_row(ACT_SPARE_7,    32'sh0f0f_0f0f,  1,  0, STAT_OK);
    add_row(ACT_POP_BACK,   '0,              1,  0, STAT_OK);
    add_row(ACT_POP_FRONT,  '0,              1,  0, STAT_OK);
    add_row(ACT_PUSH_BACK,  NO_WORD,         1,  0, STAT_OK);   // a stored all-ones word
    add_row(ACT_CLEAR,      '0,              1,  1, STAT_OK);
    // front pushes into the empty deque fill it to full depth
    add_row(ACT_PUSH_FRONT, 32'sh5555_5550,  QDEPTH, 0, STAT_OK);
    add_row(ACT_PUSH_BACK,  32'shaaaa_aaaa,  1,  0, STAT_OK);   // dropped, full
    add_row(ACT_PUSH_FRONT, '0,              1,  0, STAT_OK);   // dropped, full
    add_row(ACT_STATUS,     '0,              1,  0, STAT_OK);
    add_row(ACT_POP_BACK,   '0,              8,  0, STAT_OK);
    add_row(ACT_PUSH_BACK,  32'sh1234_5670,  4,  0, STAT_OK);
    add_row(ACT_POP_FRONT,  '0,              12, 0, STAT_OK);
    add_row(ACT_POP_BACK,   '0,              1,  1, STAT_EMPTY);
    add_row(ACT_CLEAR,      '0,              1,  1, STAT_OK);
    add_row(ACT_PUSH_BACK,  32'sh0000_0001,  1,  0, STAT_OK);
    add_row(ACT_CLEAR,      '0,              1,  1, STAT_OK);

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      for (int i = 0; i < row.reps; i++)
        send_beat(row.act, row.val + i, row.fixed, row.fixed_status);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % PHASE_LEN == 0) filling = !filling;
      act = rand_action(filling);
      send_beat(act, rand_word(), 1'b0, STAT_OK);
    end
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side: check each beat, then pick the next ready level
  initial begin
    int            stall_left;
    bit            hold_done;
    deque_result_t exp;

    stall_left = 0;
    hold_done  = 1'b0;
    out_ready  <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("tb: result beat with nothing pending, status %0d",
                                     out_status);
        end else begin
          exp = results_due[0];
          results_due.delete(0);
          if (out_status !== exp.status || out_popped_value !== exp.popped ||
              out_front_value !== exp.front || out_back_value !== exp.back ||
              out_entry_count !== exp.count || out_is_empty !== exp.empty) begin
            errors++;
            if (errors <= 10) begin
              $display("tb: mismatch exp st %0d pop %0d fr %0d bk %0d cnt %0d emp %0d",
                       exp.status, exp.popped, exp.front, exp.back, exp.count, exp.empty);
              $display("tb:          got st %0d pop %0d fr %0d bk %0d cnt %0d emp %0d",
                       out_status, out_popped_value, out_front_value, out_back_value,
                       out_entry_count, out_is_empty);
            end
          end
        end
      end
      // one long hold-off so the core backs up and drops in_ready
      if (!hold_done && beats_sent >= HOLD_AT) begin
        hold_done  = 1'b1;
        stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

endmodule
